FILE: sv/mcchc_pkg.sv
// ----------------------------------------------------------------------------
// mcchc_pkg: shared constants and helpers for the circle-hit counter
// Generator step, coordinate constants and stream field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package mcchc_pkg;

  // Generator reset and seed reset value.
  localparam logic [31:0] SEED_RESET = 32'h0000_0001;

  // Default counter width and the fixed width of the count fields.
  localparam int COUNT_BITS_DEF = 40;
  localparam int FIELD_W        = 40;

  // Stream payload widths (fields packed from bit 0, padded to bytes).
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_FIELDS  = 1 + 2 * FIELD_W;
  localparam int OUT_TDATA_W = ((OUT_FIELDS + 7) / 8) * 8;

  // Flipping the top bit turns an unsigned sample into Q1.31.
  localparam logic [31:0] SIGN_FLIP = 32'h8000_0000;

  // Unit radius squared in Q2.62.
  localparam logic [63:0] RADIUS_SQ = 64'h4000_0000_0000_0000;

  // One xorshift32 step with shifts 13, 17, 5.
  function automatic logic [31:0] xs_advance(input logic [31:0] v);
    logic [31:0] a;
    logic [31:0] b;
    a = v ^ (v << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage

`default_nettype wire

FILE: sv/monte_carlo_circle_hit_counter.sv
// ----------------------------------------------------------------------------
// monte_carlo_circle_hit_counter
// One Monte Carlo toss per input beat: xorshift32 samples give x and y, the
// toss is a hit when x^2 + y^2 <= 1, and saturating counters keep totals.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | tdata (low bit up)                        | Side
//  --------+-----------+-------------------------------------------+---------------
//  in_     | slave     | restart                                   | tlast=final_toss
//  out_    | master    | in_circle, hit_count[39:0], toss_count    | tlast=run_done
//  cfg_    | slave     | seed_value[31:0]                          | always ready
//
//  One toss is accepted per clock while the pipeline is not stalled by a low
//  out_tready. A result appears when the third register loads: one register
//  holds the coordinates, one the two squares (the multipliers), and the last
//  the hit flag and the counters.
//  Reset loads the generator and the seed with 1 and clears both counters.
//  A low out_tready holds the result; in_tready drops once all three stages
//  are full and out_tready is low.
`default_nettype none

module monte_carlo_circle_hit_counter #(
  parameter int COUNT_BITS = mcchc_pkg::COUNT_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // in_tdata: [0] restart, [7:1] zero
  input  wire logic [mcchc_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire logic                               in_tlast,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // out_tdata: [0] in_circle, [40:1] hit_count, [80:41] toss_count, rest zero
  output logic [mcchc_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                    out_tlast,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  input  wire logic [31:0]                        cfg_data,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready
);

  import mcchc_pkg::*;

  localparam int PAD_W = OUT_TDATA_W - OUT_FIELDS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [31:0] seed_r;
  logic [31:0] gen_r;

  // Stage 1: coordinates.
  logic               v1_r;
  logic signed [31:0] x_r;
  logic signed [31:0] y_r;
  logic               rs1_r;
  logic               last1_r;

  // Stage 2: squares.
  logic        v2_r;
  logic [62:0] px_r;
  logic [62:0] py_r;
  logic        rs2_r;
  logic        last2_r;

  // Stage 3: result and counters.
  logic                  v3_r;
  logic                  in_circle_r;
  logic                  last3_r;
  logic [COUNT_BITS-1:0] hit_cnt_r;
  logic [COUNT_BITS-1:0] toss_cnt_r;

  logic adv1;
  logic adv2;
  logic adv3;
  logic in_acc;

  logic [31:0]        gen_base;
  logic [31:0]        y_raw;
  logic signed [63:0] px_full;
  logic signed [63:0] py_full;
  logic [63:0]        sum;
  logic               hit;

  logic [COUNT_BITS-1:0] toss_base;
  logic [COUNT_BITS-1:0] hit_base;
  logic [COUNT_BITS-1:0] toss_cnt_nxt;
  logic [COUNT_BITS-1:0] hit_cnt_nxt;

  logic [FIELD_W-1:0] hit_out;
  logic [FIELD_W-1:0] toss_out;

  assign adv3      = !v3_r || out_tready;
  assign adv2      = !v2_r || adv3;
  assign adv1      = !v1_r || adv2;
  assign in_tready = adv1;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // A restart takes the seed in place of the running generator value.
  assign gen_base = in_tdata[0] ? seed_r : gen_r;
  assign y_raw    = xs_advance(gen_base);

  assign px_full = 64'(x_r) * 64'(x_r);
  assign py_full = 64'(y_r) * 64'(y_r);

  assign sum = {1'b0, px_r} + {1'b0, py_r};
  assign hit = (sum <= RADIUS_SQ);

  assign toss_base    = rs2_r ? '0 : toss_cnt_r;
  assign hit_base     = rs2_r ? '0 : hit_cnt_r;
  assign toss_cnt_nxt = (toss_base == COUNT_MAX) ? toss_base :
                        toss_base + COUNT_BITS'(1);
  assign hit_cnt_nxt  = !hit ? hit_base :
                        (hit_base == COUNT_MAX) ? hit_base : hit_base + COUNT_BITS'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      seed_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r <= SEED_RESET;
    end else if (in_acc) begin
      gen_r <= xs_advance(y_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv1) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r     <= gen_base ^ SIGN_FLIP;
      y_r     <= y_raw ^ SIGN_FLIP;
      rs1_r   <= in_tdata[0];
      last1_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1_r) begin
      px_r    <= px_full[62:0];
      py_r    <= py_full[62:0];
      rs2_r   <= rs1_r;
      last2_r <= last1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r       <= 1'b0;
      hit_cnt_r  <= '0;
      toss_cnt_r <= '0;
    end else if (adv3) begin
      v3_r <= v2_r;
      if (v2_r) begin
        hit_cnt_r  <= hit_cnt_nxt;
        toss_cnt_r <= toss_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && v2_r) begin
      in_circle_r <= hit;
      last3_r     <= last2_r;
    end
  end

  // The count fields are 40 bits wide whatever the counter width.
  generate
    if (COUNT_BITS >= FIELD_W) begin : g_cnt_trunc
      assign hit_out  = hit_cnt_r[FIELD_W-1:0];
      assign toss_out = toss_cnt_r[FIELD_W-1:0];
    end else begin : g_cnt_ext
      assign hit_out  = {{(FIELD_W - COUNT_BITS){1'b0}}, hit_cnt_r};
      assign toss_out = {{(FIELD_W - COUNT_BITS){1'b0}}, toss_cnt_r};
    end
  endgenerate

  assign out_tdata  = {{PAD_W{1'b0}}, toss_out, hit_out, in_circle_r};
  assign out_tlast  = last3_r;
  assign out_tvalid = v3_r;

  // Hits can never outnumber tosses.
  a_hits_le_tosses: assert property (@(posedge clk) disable iff (!rst_n)
    hit_cnt_r <= toss_cnt_r)
    else $error("hit counter exceeds toss counter");

  // A zero generator stays zero until a restart reloads it.
  a_zero_gen_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (gen_r == '0) && !(in_acc && in_tdata[0]) |=> (gen_r == '0))
    else $error("zero generator left zero without restart");

  // Without a restart the toss counter only moves up by one or holds.
  a_toss_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    adv3 && v2_r && !rs2_r |=> (toss_cnt_r >= $past(toss_cnt_r)))
    else $error("toss counter went backward");

  // A result flagged as a hit carries a nonzero hit count.
  a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && in_circle_r |-> (hit_cnt_r != '0))
    else $error("hit result with zero hit count");

endmodule

`default_nettype wire
